// ----- rtl/core/udpmb_pkg.sv -----
`default_nettype none

package udpmb_pkg;

   localparam int SLOTS        = 8;
   localparam int BUFFER_BYTES = 1024;

   localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int OFS_W   = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
   localparam int LEN_W   = $clog2(BUFFER_BYTES + 1);
   localparam int PAY_AW  = SLOT_W + OFS_W;
   localparam int META_W  = 48;

   typedef enum logic [2:0] {
      CMD_BIND    = 3'd0,
      CMD_UNBIND  = 3'd1,
      CMD_HEADER  = 3'd2,
      CMD_PAYLOAD = 3'd3,
      CMD_TAKE    = 3'd4,
      CMD_READ    = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NO_SLOT = 2'd1,
      ST_EMPTY   = 2'd2
   } status_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [15:0] port;
      logic [31:0] src_ip;
      logic [15:0] src_port;
      logic [15:0] udp_length;
      logic [7:0]  payload_byte;
      logic        last;
      logic [2:0]  slot;
      logic [9:0]  offset;
      logic [10:0] max_len;
   } req_type;

   // result of one word before the memory data is merged in
   typedef struct packed {
      logic       has_result;
      status_type status;
      logic [2:0] slot_out;
      logic [10:0] length;
      logic       from_meta;
      logic       from_pay;
   } stage_type;

   typedef struct packed {
      logic              we;
      logic              re;
      logic [PAY_AW-1:0] addr;
      logic [7:0]        wdata;
   } pay_req_type;

   typedef struct packed {
      logic              we;
      logic              re;
      logic [SLOT_W-1:0] addr;
      logic [META_W-1:0] wdata;
   } meta_req_type;

endpackage

`default_nettype wire

// ----- rtl/core/udpmb_if.sv -----
`default_nettype none

interface udpmb_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [15:0] port;
   logic [31:0] src_ip;
   logic [15:0] src_port;
   logic [15:0] udp_length;
   logic [7:0]  payload_byte;
   logic        last;
   logic [2:0]  slot;
   logic [9:0]  offset;
   logic [10:0] max_len;

   modport source (
      output valid, cmd, port, src_ip, src_port, udp_length, payload_byte, last,
             slot, offset, max_len,
      input  ready
   );
   modport sink (
      input  valid, cmd, port, src_ip, src_port, udp_length, payload_byte, last,
             slot, offset, max_len,
      output ready
   );
endinterface

interface udpmb_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [2:0]  slot_out;
   logic [10:0] length;
   logic [31:0] from_ip;
   logic [15:0] sender_port;
   logic [7:0]  data_out;

   modport source (
      output valid, status, slot_out, length, from_ip, sender_port, data_out,
      input  ready
   );
   modport sink (
      input  valid, status, slot_out, length, from_ip, sender_port, data_out,
      output ready
   );
endinterface

`default_nettype wire

// ----- rtl/core/udpmb_ram.sv -----
`default_nettype none

module udpmb_ram #(
   parameter int DATA_W = 8,
   parameter int ADDR_W = 4
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [DATA_W-1:0] wdata,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [DATA_W-1:0] rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rd_data_ff <= mem_ff[raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/udpmb_ctrl.sv -----
`default_nettype none

module udpmb_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    accept,
   input  wire udpmb_pkg::req_type      item,
   output udpmb_pkg::stage_type         result,
   output udpmb_pkg::pay_req_type       pay_req,
   output udpmb_pkg::meta_req_type      meta_req
);

   import udpmb_pkg::*;

   logic [15:0]       bound_ff [SLOTS];
   logic [15:0]       bound_in [SLOTS];
   logic [LEN_W-1:0]  size_ff  [SLOTS];
   logic [LEN_W-1:0]  size_in  [SLOTS];

   logic              rx_active_ff, rx_active_in;
   logic [SLOT_W-1:0] rx_slot_ff, rx_slot_in;
   logic [LEN_W-1:0]  rx_length_ff, rx_length_in;
   logic [LEN_W-1:0]  rx_pointer_ff, rx_pointer_in;
   logic [31:0]       rx_ip_ff, rx_ip_in;
   logic [15:0]       rx_sport_ff, rx_sport_in;

   logic              bind_hit, unb_hit, hdr_hit;
   logic [SLOT_W-1:0] bind_idx, unb_idx, hdr_idx;

   cmd_type           cmd;
   logic [SLOT_W-1:0] sidx;
   logic              slot_ok;
   logic [15:0]       len_raw;
   logic [LEN_W-1:0]  hdr_len;
   logic              rx_store;
   logic [LEN_W-1:0]  rx_ptr_next;
   logic [10:0]       held_len;

   assign cmd     = cmd_type'(item.cmd);
   assign sidx    = item.slot[SLOT_W-1:0];
   assign slot_ok = int'(item.slot) < SLOTS;
   assign len_raw = item.udp_length - 16'd8;
   assign hdr_len = (len_raw > 16'(BUFFER_BYTES)) ? LEN_W'(BUFFER_BYTES)
                                                  : len_raw[LEN_W-1:0];
   assign rx_store    = rx_pointer_ff < rx_length_ff;
   assign rx_ptr_next = rx_store ? rx_pointer_ff + LEN_W'(1) : rx_pointer_ff;
   assign held_len    = 11'(size_ff[sidx]);

   // parallel port searches, lowest slot wins
   always_comb begin
      bind_hit = 1'b0;
      bind_idx = '0;
      unb_hit  = 1'b0;
      unb_idx  = '0;
      hdr_hit  = 1'b0;
      hdr_idx  = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (bound_ff[i] == item.port || bound_ff[i] == 16'd0) begin
            bind_hit = 1'b1;
            bind_idx = SLOT_W'(i);
         end
         if (bound_ff[i] == item.port) begin
            unb_hit = 1'b1;
            unb_idx = SLOT_W'(i);
         end
         if (bound_ff[i] != 16'd0 && bound_ff[i] == item.port) begin
            hdr_hit = 1'b1;
            hdr_idx = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      bound_in      = bound_ff;
      size_in       = size_ff;
      rx_active_in  = rx_active_ff;
      rx_slot_in    = rx_slot_ff;
      rx_length_in  = rx_length_ff;
      rx_pointer_in = rx_pointer_ff;
      rx_ip_in      = rx_ip_ff;
      rx_sport_in   = rx_sport_ff;
      result        = '0;
      pay_req       = '0;
      meta_req      = '0;
      if (accept) begin
         unique case (cmd)
            CMD_BIND: begin
               result.has_result = 1'b1;
               if (bind_hit) begin
                  bound_in[bind_idx] = item.port;
                  result.slot_out    = 3'(bind_idx);
               end else begin
                  result.status = ST_NO_SLOT;
               end
            end
            CMD_UNBIND: begin
               result.has_result = 1'b1;
               if (unb_hit) begin
                  bound_in[unb_idx] = 16'd0;
                  size_in[unb_idx]  = '0;
                  if (rx_active_ff && rx_slot_ff == unb_idx) begin
                     rx_active_in = 1'b0;
                  end
               end else begin
                  result.status = ST_NO_SLOT;
               end
            end
            CMD_HEADER: begin
               result.has_result = 1'b1;
               rx_active_in      = 1'b0;
               if (hdr_hit) begin
                  result.slot_out = 3'(hdr_idx);
                  rx_slot_in      = hdr_idx;
                  rx_length_in    = hdr_len;
                  rx_pointer_in   = '0;
                  rx_ip_in        = item.src_ip;
                  rx_sport_in     = item.src_port;
                  if (hdr_len == '0) begin
                     // empty packet commits at once
                     size_in[hdr_idx] = '0;
                     meta_req.we      = 1'b1;
                     meta_req.addr    = hdr_idx;
                     meta_req.wdata   = {item.src_ip, item.src_port};
                  end else begin
                     rx_active_in = 1'b1;
                  end
               end else begin
                  result.status = ST_NO_SLOT;
               end
            end
            CMD_PAYLOAD: begin
               if (rx_active_ff) begin
                  pay_req.we    = rx_store;
                  pay_req.addr  = {rx_slot_ff, rx_pointer_ff[OFS_W-1:0]};
                  pay_req.wdata = item.payload_byte;
                  rx_pointer_in = rx_ptr_next;
                  if (item.last) begin
                     size_in[rx_slot_ff] = rx_ptr_next;
                     meta_req.we         = 1'b1;
                     meta_req.addr       = rx_slot_ff;
                     meta_req.wdata      = {rx_ip_ff, rx_sport_ff};
                     rx_active_in        = 1'b0;
                  end
               end
            end
            CMD_TAKE: begin
               result.has_result = 1'b1;
               if (!slot_ok) begin
                  result.status = ST_NO_SLOT;
               end else if (held_len == 11'd0) begin
                  result.status = ST_EMPTY;
               end else begin
                  result.length    = (item.max_len < held_len) ? item.max_len : held_len;
                  result.from_meta = 1'b1;
                  meta_req.re      = 1'b1;
                  meta_req.addr    = sidx;
                  size_in[sidx]    = '0;
               end
            end
            CMD_READ: begin
               result.has_result = 1'b1;
               if (!slot_ok) begin
                  result.status = ST_NO_SLOT;
               end else if (11'(item.offset) >= held_len) begin
                  result.status = ST_EMPTY;
               end else begin
                  result.from_pay = 1'b1;
                  pay_req.re      = 1'b1;
                  pay_req.addr    = {sidx, item.offset[OFS_W-1:0]};
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            bound_ff[i] <= '0;
            size_ff[i]  <= '0;
         end
         rx_active_ff  <= 1'b0;
         rx_slot_ff    <= '0;
         rx_length_ff  <= '0;
         rx_pointer_ff <= '0;
         rx_ip_ff      <= '0;
         rx_sport_ff   <= '0;
      end else begin
         bound_ff      <= bound_in;
         size_ff       <= size_in;
         rx_active_ff  <= rx_active_in;
         rx_slot_ff    <= rx_slot_in;
         rx_length_ff  <= rx_length_in;
         rx_pointer_ff <= rx_pointer_in;
         rx_ip_ff      <= rx_ip_in;
         rx_sport_ff   <= rx_sport_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/udp_port_demux_mailbox_top.sv -----
// UDP receive port table with one single-packet mailbox per slot.
// req channel: one command word per handshake (bind, unbind, packet header,
// payload byte, take, read byte). rsp channel: one result word for every
// command except payload bytes and unused codes, in command order.
// A word is taken when valid and ready are both high.
// Throughput: one command word per cycle, including back-to-back payload
// bytes, unless a result word is blocked. Each result word passes an
// internal stage and the output registers; payload and metadata memories
// are read on accept and their registered data joins it at the output.
// The port table and mailbox sizes sit in flip-flops and are searched in
// parallel; payload bytes and sender metadata sit in synchronous memories.
// Reset (synchronous, active high) frees all slots, empties all mailboxes
// and drops any reception; the payload memory needs no clearing pass.
// When the receiver holds rsp ready low, one more result word waits in an
// internal stage and then req ready drops until the output drains.
`default_nettype none

module udp_port_demux_mailbox_top (
   input wire logic      clock,
   input wire logic      reset,
   udpmb_req_if.sink     req,
   udpmb_rsp_if.source   rsp
);

   import udpmb_pkg::*;

   req_type      item;
   stage_type    result;
   pay_req_type  pay_req;
   meta_req_type meta_req;
   logic         accept;
   logic [7:0]        pay_rdata;
   logic [META_W-1:0] meta_rdata;

   logic      s1_valid_ff, s1_valid_in;
   stage_type s1_ff, s1_in;
   logic      s1_adv;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  status_ff, status_in;
   logic [2:0]  slot_out_ff, slot_out_in;
   logic [10:0] length_ff, length_in;
   logic [31:0] from_ip_ff, from_ip_in;
   logic [15:0] sender_port_ff, sender_port_in;
   logic [7:0]  data_out_ff, data_out_in;

   assign item = '{
      cmd:          req.cmd,
      port:         req.port,
      src_ip:       req.src_ip,
      src_port:     req.src_port,
      udp_length:   req.udp_length,
      payload_byte: req.payload_byte,
      last:         req.last,
      slot:         req.slot,
      offset:       req.offset,
      max_len:      req.max_len
   };

   assign s1_adv    = s1_valid_ff && (!s1_ff.has_result || !rsp_valid_ff || rsp.ready);
   assign req.ready = !s1_valid_ff || s1_adv;
   assign accept    = req.valid && req.ready;

   udpmb_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .item     (item),
      .result   (result),
      .pay_req  (pay_req),
      .meta_req (meta_req)
   );

   udpmb_ram #(.DATA_W(8), .ADDR_W(PAY_AW)) u_pay_ram (
      .clock   (clock),
      .we      (pay_req.we),
      .waddr   (pay_req.addr),
      .wdata   (pay_req.wdata),
      .re      (pay_req.re),
      .raddr   (pay_req.addr),
      .rd_data (pay_rdata)
   );

   udpmb_ram #(.DATA_W(META_W), .ADDR_W(SLOT_W)) u_meta_ram (
      .clock   (clock),
      .we      (meta_req.we),
      .waddr   (meta_req.addr),
      .wdata   (meta_req.wdata),
      .re      (meta_req.re),
      .raddr   (meta_req.addr),
      .rd_data (meta_rdata)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_in       = s1_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_in       = result;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      status_in      = status_ff;
      slot_out_in    = slot_out_ff;
      length_in      = length_ff;
      from_ip_in     = from_ip_ff;
      sender_port_in = sender_port_ff;
      data_out_in    = data_out_ff;
      if (s1_adv && s1_ff.has_result) begin
         rsp_valid_in   = 1'b1;
         status_in      = s1_ff.status;
         slot_out_in    = s1_ff.slot_out;
         length_in      = s1_ff.length;
         from_ip_in     = s1_ff.from_meta ? meta_rdata[47:16] : 32'd0;
         sender_port_in = s1_ff.from_meta ? meta_rdata[15:0] : 16'd0;
         data_out_in    = s1_ff.from_pay ? pay_rdata : 8'd0;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff          <= s1_in;
      status_ff      <= status_in;
      slot_out_ff    <= slot_out_in;
      length_ff      <= length_in;
      from_ip_ff     <= from_ip_in;
      sender_port_ff <= sender_port_in;
      data_out_ff    <= data_out_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = status_ff;
   assign rsp.slot_out    = slot_out_ff;
   assign rsp.length      = length_ff;
   assign rsp.from_ip     = from_ip_ff;
   assign rsp.sender_port = sender_port_ff;
   assign rsp.data_out    = data_out_ff;

`ifndef SYNTHESIS
   a_rsp_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> $past(s1_valid_ff && s1_ff.has_result))
      else $error("result word appeared without a pending stage entry");

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_ff.has_result && rsp_valid_ff && !rsp.ready) |-> !req.ready)
      else $error("command taken while a result is blocked");

   a_fail_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status != ST_OK) |->
         (rsp.length == 11'd0 && rsp.data_out == 8'd0 && rsp.from_ip == 32'd0))
      else $error("failed command returned data");
`endif

endmodule

`default_nettype wire

// ----- sim/udpmb_mailbox_checker.sv -----
`timescale 1ns / 100ps

module udpmb_mailbox_checker
   import udpmb_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   udpmb_req_if      req_bus,
   udpmb_rsp_if      rsp_bus,
   output int        mismatch_count,
   output int        replies_owed
);

   typedef struct packed {
      status_type  status;
      logic [2:0]  slot_out;
      logic [10:0] length;
      logic [31:0] from_ip;
      logic [15:0] sender_port;
      logic [7:0]  data_out;
   } reply_type;

   logic [15:0]       port_of  [SLOTS];
   logic [10:0]       size_of  [SLOTS];
   logic [31:0]       ip_of    [SLOTS];
   logic [15:0]       sport_of [SLOTS];
   logic [7:0]        bytes_of [SLOTS * BUFFER_BYTES];
   logic              rx_on;
   logic [SLOT_W-1:0] rx_idx;
   logic [LEN_W-1:0]  rx_len;
   logic [LEN_W-1:0]  rx_cnt;
   logic [31:0]       rx_from_ip;
   logic [15:0]       rx_src_port;

   reply_type owed_q [$];
   reply_type got;
   reply_type want;
   req_type   word;

   function automatic string reply_text(input reply_type r);
      return $sformatf("status %0d slot %0d length %0d ip %h port %h data %h",
                       r.status, r.slot_out, r.length, r.from_ip, r.sender_port,
                       r.data_out);
   endfunction

   function automatic void seal_packet();
      size_of[rx_idx]  = rx_cnt;
      ip_of[rx_idx]    = rx_from_ip;
      sport_of[rx_idx] = rx_src_port;
      rx_on            = 1'b0;
   endfunction

   // returns 1 when the word produces a result word
   function automatic bit mailbox_step(input req_type w, output reply_type r);
      bit          found;
      logic [15:0] len16;
      found = 1'b0;
      r     = '0;
      case (w.cmd)
         CMD_BIND: begin
            r.status = ST_NO_SLOT;
            for (int i = 0; i < SLOTS; i++) begin
               if (!found && (port_of[i] == w.port || port_of[i] == 16'd0)) begin
                  found      = 1'b1;
                  port_of[i] = w.port;
                  r.status   = ST_OK;
                  r.slot_out = 3'(i);
               end
            end
            return 1'b1;
         end
         CMD_UNBIND: begin
            r.status = ST_NO_SLOT;
            for (int i = 0; i < SLOTS; i++) begin
               if (!found && port_of[i] == w.port) begin
                  found      = 1'b1;
                  port_of[i] = 16'd0;
                  size_of[i] = '0;
                  if (rx_on && int'(rx_idx) == i) rx_on = 1'b0;
                  r.status   = ST_OK;
               end
            end
            return 1'b1;
         end
         CMD_HEADER: begin
            rx_on    = 1'b0;
            r.status = ST_NO_SLOT;
            for (int i = 0; i < SLOTS; i++) begin
               if (!found && port_of[i] != 16'd0 && port_of[i] == w.port) begin
                  found        = 1'b1;
                  len16        = w.udp_length - 16'd8;
                  rx_idx       = SLOT_W'(i);
                  rx_len       = (len16 > BUFFER_BYTES) ? LEN_W'(BUFFER_BYTES)
                                                        : LEN_W'(len16);
                  rx_cnt       = '0;
                  rx_from_ip   = w.src_ip;
                  rx_src_port  = w.src_port;
                  rx_on        = 1'b1;
                  if (rx_len == '0) seal_packet();
                  r.status     = ST_OK;
                  r.slot_out   = 3'(i);
               end
            end
            return 1'b1;
         end
         CMD_PAYLOAD: begin
            if (!rx_on) return 1'b0;
            if (rx_cnt < rx_len) begin
               bytes_of[{rx_idx, rx_cnt[OFS_W-1:0]}] = w.payload_byte;
               rx_cnt = rx_cnt + 1'b1;
            end
            if (w.last) seal_packet();
            return 1'b0;
         end
         CMD_TAKE: begin
            if (size_of[w.slot] == '0) begin
               r.status = ST_EMPTY;
            end else begin
               r.length      = (w.max_len < size_of[w.slot]) ? w.max_len : size_of[w.slot];
               r.from_ip     = ip_of[w.slot];
               r.sender_port = sport_of[w.slot];
               size_of[w.slot] = '0;
            end
            return 1'b1;
         end
         CMD_READ: begin
            if (w.offset >= size_of[w.slot]) r.status = ST_EMPTY;
            else r.data_out = bytes_of[{w.slot, w.offset}];
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            port_of[i]  = '0;
            size_of[i]  = '0;
            ip_of[i]    = '0;
            sport_of[i] = '0;
         end
         rx_on        = 1'b0;
         rx_idx       = '0;
         rx_len       = '0;
         rx_cnt       = '0;
         rx_from_ip   = '0;
         rx_src_port  = '0;
         owed_q.delete();
         mismatch_count <= 0;
      end else begin
         // result word first, then the command word taken at this edge
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = {rsp_bus.status, rsp_bus.slot_out, rsp_bus.length, rsp_bus.from_ip,
                   rsp_bus.sender_port, rsp_bus.data_out};
            if (owed_q.size() == 0) begin
               $display("%0t unexpected result word: %s", $time, reply_text(got));
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = owed_q.pop_front();
               if (got !== want) begin
                  $display("%0t result mismatch: expected %s", $time, reply_text(want));
                  $display("%0t                  actual   %s", $time, reply_text(got));
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            word = {req_bus.cmd, req_bus.port, req_bus.src_ip, req_bus.src_port,
                    req_bus.udp_length, req_bus.payload_byte, req_bus.last,
                    req_bus.slot, req_bus.offset, req_bus.max_len};
            if (mailbox_step(word, want)) owed_q.push_back(want);
         end
      end
      replies_owed <= owed_q.size();
   end

endmodule

// ----- sim/udp_port_demux_mailbox_top_tb.sv -----
`timescale 1ns / 100ps

module udp_port_demux_mailbox_top_tb;
   import udpmb_pkg::*;

   localparam int QUIET_LIMIT   = 4000;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_WORDS   = 75;
   localparam int LONG_BYTES    = 48;

   localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
   localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

   logic clock;
   logic reset;
   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   int   hold_request   = 0;
   int   hold_seen      = 0;
   int   hold_left      = 0;
   int   quiet_cycles   = 0;
   int   words_sent     = 0;
   int   phase_start;
   int   mismatch_count;
   int   replies_owed;

   udpmb_req_if req_if ();
   udpmb_rsp_if rsp_if ();

   udp_port_demux_mailbox_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   udpmb_mailbox_checker mailbox_checker (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_if),
      .rsp_bus        (rsp_if),
      .mismatch_count (mismatch_count),
      .replies_owed   (replies_owed)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_request != hold_seen) begin
         hold_seen    <= hold_request;
         hold_left    <= HOLD_CYCLES;
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left    <= hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("%0t watchdog: no word moved for %0d cycles", $time, QUIET_LIMIT);
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_type noise_word();
      req_type w;
      w.cmd          = 3'($urandom_range(7));
      w.port         = 16'($urandom);
      w.src_ip       = $urandom;
      w.src_port     = 16'($urandom);
      w.udp_length   = 16'($urandom);
      w.payload_byte = 8'($urandom);
      w.last         = 1'($urandom);
      w.slot         = 3'($urandom);
      w.offset       = 10'($urandom);
      w.max_len      = 11'($urandom);
      return w;
   endfunction

   // small pool larger than the table, so binds also fail
   function automatic logic [15:0] pick_port();
      int r;
      r = $urandom_range(19);
      if (r < 11) return 16'($urandom_range(1, 6));
      if (r < 17) return 16'($urandom_range(16'hFFFB, 16'hFFFF));
      if (r < 19) return 16'($urandom);
      return 16'd0;
   endfunction

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_stall_pct <= recv_pct;
   endtask

   task automatic send_word(input req_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.cmd          <= w.cmd;
      req_if.port         <= w.port;
      req_if.src_ip       <= w.src_ip;
      req_if.src_port     <= w.src_port;
      req_if.udp_length   <= w.udp_length;
      req_if.payload_byte <= w.payload_byte;
      req_if.last         <= w.last;
      req_if.slot         <= w.slot;
      req_if.offset       <= w.offset;
      req_if.max_len      <= w.max_len;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (w.cmd < CMD_UNUSED_LO) words_sent++;
   endtask

   task automatic port_cmd(input cmd_type c, input logic [15:0] p);
      req_type w;
      w      = noise_word();
      w.cmd  = c;
      w.port = p;
      send_word(w);
   endtask

   task automatic slot_cmd(input cmd_type c, input logic [2:0] s, input logic [9:0] ofs,
                           input logic [10:0] mlen);
      req_type w;
      w         = noise_word();
      w.cmd     = c;
      w.slot    = s;
      w.offset  = ofs;
      w.max_len = mlen;
      send_word(w);
   endtask

   task automatic header(input logic [15:0] p, input logic [15:0] ulen,
                         input logic [31:0] ip, input logic [15:0] sp);
      req_type w;
      w            = noise_word();
      w.cmd        = CMD_HEADER;
      w.port       = p;
      w.udp_length = ulen;
      w.src_ip     = ip;
      w.src_port   = sp;
      send_word(w);
   endtask

   task automatic payload(input logic [7:0] b, input bit fin);
      req_type w;
      w              = noise_word();
      w.cmd          = CMD_PAYLOAD;
      w.payload_byte = b;
      w.last         = fin;
      send_word(w);
   endtask

   task automatic spare_cmd(input logic [2:0] c);
      req_type w;
      w     = noise_word();
      w.cmd = c;
      send_word(w);
   endtask

   task automatic random_op();
      int          r;
      int          n;
      int          k;
      logic [15:0] ulen;
      r = $urandom_range(99);
      if (r < 12) begin
         port_cmd(CMD_BIND, pick_port());
      end else if (r < 18) begin
         port_cmd(CMD_UNBIND, pick_port());
      end else if (r < 55) begin
         n = $urandom_range(12);
         k = $urandom_range(9);
         if (k < 6) ulen = 16'(n + 8);
         else if (k < 8) ulen = 16'(n + 8 + $urandom_range(1, 6));
         else if (k < 9) ulen = 16'($urandom_range(n + 8));
         else ulen = 16'($urandom);
         header(pick_port(), ulen, $urandom, 16'($urandom));
         // now and then the last flag never comes
         for (int b = 0; b < n; b++)
            payload(8'($urandom), (b == n - 1) && ($urandom_range(15) != 0));
      end else if (r < 72) begin
         slot_cmd(CMD_TAKE, 3'($urandom), 10'($urandom),
                  $urandom_range(1) ? 11'($urandom) : 11'($urandom_range(16)));
      end else if (r < 95) begin
         slot_cmd(CMD_READ, 3'($urandom),
                  ($urandom_range(9) < 7) ? 10'($urandom_range(15)) : 10'($urandom),
                  11'($urandom));
      end else if ($urandom_range(1)) begin
         spare_cmd($urandom_range(1) ? CMD_UNUSED_LO : CMD_UNUSED_HI);
      end else begin
         send_word(noise_word());
      end
   endtask

   task automatic drain_replies();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (replies_owed != 0);
   endtask

   initial begin
      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.cmd          <= CMD_BIND;
      req_if.port         <= '0;
      req_if.src_ip       <= '0;
      req_if.src_port     <= '0;
      req_if.udp_length   <= '0;
      req_if.payload_byte <= '0;
      req_if.last         <= 1'b0;
      req_if.slot         <= '0;
      req_if.offset       <= '0;
      req_if.max_len      <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty table and mailboxes
      slot_cmd(CMD_TAKE, 3'd7, 10'd0, 11'd0);
      slot_cmd(CMD_READ, 3'd0, 10'd0, 11'd0);
      port_cmd(CMD_UNBIND, 16'd5);
      header(16'd0, 16'd20, 32'h0, 16'h0);
      payload(8'h5A, 1'b1);
      port_cmd(CMD_BIND, 16'd0);
      port_cmd(CMD_BIND, 16'hFFFF);
      port_cmd(CMD_BIND, 16'd1);
      port_cmd(CMD_BIND, 16'hFFFF);
      // bytes past the length are dropped
      header(16'hFFFF, 16'd11, 32'hFFFF_FFFF, 16'hFFFF);
      payload(8'hFF, 1'b0);
      payload(8'h00, 1'b0);
      payload(8'hAA, 1'b0);
      payload(8'h55, 1'b1);
      slot_cmd(CMD_READ, 3'd0, 10'd2, 11'd0);
      slot_cmd(CMD_READ, 3'd0, 10'd3, 11'd0);
      slot_cmd(CMD_TAKE, 3'd0, 10'd0, 11'h7FF);
      // zero length packet
      header(16'd1, 16'd8, 32'h8000_0001, 16'h8001);
      slot_cmd(CMD_TAKE, 3'd1, 10'd0, 11'd4);
      // length wraps and clamps, early last
      header(16'd1, 16'd0, 32'h0123_4567, 16'h89AB);
      payload(8'h12, 1'b0);
      payload(8'h34, 1'b1);
      slot_cmd(CMD_TAKE, 3'd1, 10'd0, 11'd1);
      // unbind drops the reception in progress
      header(16'd1, 16'd20, 32'h7654_3210, 16'h0F0F);
      payload(8'h77, 1'b0);
      port_cmd(CMD_UNBIND, 16'd1);
      payload(8'h88, 1'b1);
      spare_cmd(CMD_UNUSED_LO);
      spare_cmd(CMD_UNUSED_HI);
      drain_replies();

      // long receiver hold while words keep coming
      set_idling(0, 0);
      hold_request <= hold_request + 1;
      repeat (40) begin
         if ($urandom_range(1))
            slot_cmd(CMD_READ, 3'($urandom), 10'($urandom_range(15)), 11'($urandom));
         else
            port_cmd(CMD_BIND, pick_port());
      end
      drain_replies();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: set_idling(0, 0);
            1: set_idling(64, 0);
            2: set_idling(0, 64);
            default: set_idling(25, 25);
         endcase
         phase_start = words_sent;
         while (words_sent - phase_start < PHASE_WORDS) random_op();
         drain_replies();
      end

      // one long clamped packet, read back at its top offset
      port_cmd(CMD_UNBIND, 16'd3);
      port_cmd(CMD_BIND, 16'd3);
      header(16'd3, 16'hFFFF, $urandom, 16'($urandom));
      for (int b = 0; b < LONG_BYTES; b++) payload(8'($urandom), b == LONG_BYTES - 1);
      for (int s = 0; s < SLOTS; s++) begin
         slot_cmd(CMD_READ, 3'(s), 10'(LONG_BYTES - 1), 11'($urandom));
         repeat (3) slot_cmd(CMD_READ, 3'(s), 10'($urandom), 11'($urandom));
         slot_cmd(CMD_TAKE, 3'(s), 10'($urandom), 11'h7FF);
      end
      drain_replies();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && replies_owed == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
